@@ src/aid_pkg.sv @@
// aid_pkg: shared types, constants and the microcode rom of the ata identify sequencer
// depends on nothing; used by every module of the block by scoped names
`timescale 1ns / 1ps

package aid_pkg;

    // identify data layout
    localparam int IDENTIFY_WORDS = 256;
    localparam int WORD_W         = $clog2(IDENTIFY_WORDS);
    localparam int SERIAL_CHARS   = 20;
    localparam int CHAR_COUNT     = 60;
    localparam int TEXT_WORDS     = CHAR_COUNT / 2;
    localparam int TEXT_AW        = $clog2(TEXT_WORDS);
    localparam int CHAR_W         = 6;

    localparam logic [WORD_W-1:0] W_SERIAL_LO = WORD_W'(10);
    localparam logic [WORD_W-1:0] W_SERIAL_HI = WORD_W'(19);
    localparam logic [WORD_W-1:0] W_MODEL_LO  = WORD_W'(27);
    localparam logic [WORD_W-1:0] W_MODEL_HI  = WORD_W'(46);
    localparam logic [WORD_W-1:0] W_CAP28_LO  = WORD_W'(60);
    localparam logic [WORD_W-1:0] W_CAP28_HI  = WORD_W'(61);
    localparam logic [WORD_W-1:0] W_CMDSET    = WORD_W'(83);
    localparam logic [WORD_W-1:0] W_CAP48_LO  = WORD_W'(100);
    localparam logic [WORD_W-1:0] W_CAP48_HI  = WORD_W'(103);
    localparam int                LBA48_BIT   = 10;
    localparam int                CAP_WORDS   = 6;
    // capacity slot of word 100 is 2: slot = word - CAP48_SHIFT
    localparam logic [WORD_W-1:0] CAP48_SHIFT = WORD_W'(98);

    localparam logic [2:0] MAX_DEVICES = 3'd4;

    // ata register bytes and bits
    localparam logic [7:0] SEL_MASTER   = 8'hA0;
    localparam logic [7:0] SEL_SLAVE    = 8'hB0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] ST_BSY       = 8'h80;
    localparam logic [7:0] ST_DRQ       = 8'h08;
    localparam logic [7:0] ST_ERR       = 8'h01;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // offsets inside the command block
    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_LBA0   = 3'd3;
    localparam logic [2:0] REG_LBA1   = 3'd4;
    localparam logic [2:0] REG_LBA2   = 3'd5;
    localparam logic [2:0] REG_DEVICE = 3'd6;
    localparam logic [2:0] REG_CMDST  = 3'd7;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W    = 17;

    typedef enum logic [1:0] {
        CFG_COMMAND_BASE = 2'd0,
        CFG_CONTROL_PORT = 2'd1,
        CFG_POLL_LIMIT   = 2'd2
    } cfg_index_t;

    localparam logic [15:0]        RST_COMMAND_BASE = 16'h01F0;
    localparam logic [15:0]        RST_CONTROL_PORT = 16'h03F6;
    localparam logic [LIMIT_W-1:0] RST_POLL_LIMIT   = LIMIT_W'(100000);

    typedef struct packed {
        logic [15:0]        command_base;
        logic [15:0]        control_port;
        logic [LIMIT_W-1:0] poll_limit;
    } cfg_t;

    // input operation codes
    localparam logic OPER_START    = 1'b0;
    localparam logic OPER_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        K_WRITE     = 3'd0,
        K_READ_BYTE = 3'd1,
        K_READ_WORD = 3'd2,
        K_CHAR      = 3'd3,
        K_REPORT    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        O_FOUND       = 3'd0,
        O_NO_DEVICE   = 3'd1,
        O_BSY_TIMEOUT = 3'd2,
        O_DRQ_TIMEOUT = 3'd3,
        O_DEV_ERROR   = 3'd4
    } outcome_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_WAIT_SEL = 4'd1,
        PH_WAIT_CMD = 4'd2,
        PH_STATUS   = 4'd3,
        PH_BSY      = 4'd4,
        PH_DRQ      = 4'd5,
        PH_DATA     = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        P_NONE = 2'd0,
        P_CMD  = 2'd1,
        P_CTRL = 2'd2
    } port_sel_t;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_START_CLR = 4'd1,
        OP_DELAY_INC = 4'd2,
        OP_POLL_ONE  = 4'd3,
        OP_POLL_INC  = 4'd4,
        OP_WORD_CLR  = 4'd5,
        OP_TAKE_WORD = 4'd6,
        OP_CHAR_CLR  = 4'd7,
        OP_CHAR_INC  = 4'd8,
        OP_FOUND_INC = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER       = 4'd0,
        C_ALWAYS      = 4'd1,
        C_DELAY_WRAP  = 4'd2,
        C_PHASE_CMD   = 4'd3,
        C_STATUS_ZERO = 4'd4,
        C_NOT_BSY     = 4'd5,
        C_POLL_DONE   = 4'd6,
        C_POLL_MORE   = 4'd7,
        C_ERR         = 4'd8,
        C_DRQ         = 4'd9,
        C_WORD_LAST   = 4'd10,
        C_CHAR_MORE   = 4'd11
    } cond_t;

    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        logic      wait_in;
        logic      emit;
        kind_t     kind;
        port_sel_t port;
        logic [2:0] off;
        logic      drv_val;
        logic [7:0] wval;
        outcome_t  outcome;
        logic      last;
        logic      ph_we;
        phase_t    ph;
        op_t       op;
        cond_t     cond;
        upc_t      target;
    } uword_t;

    // datapath flags seen by the jump logic
    typedef struct packed {
        phase_t phase;
        logic   delay_wrap;
        logic   status_zero;
        logic   not_bsy;
        logic   poll_done;
        logic   err;
        logic   drq;
        logic   word_last;
        logic   char_more;
    } flags_t;

    // datapath to store
    typedef struct packed {
        logic              clr;
        logic              take;
        logic [WORD_W-1:0] word_idx;
        logic [15:0]       data;
        logic [CHAR_W-1:0] char_idx;
    } store_ctl_t;

    // program addresses
    localparam upc_t U_WAIT       = 6'd0;
    localparam upc_t U_START      = 6'd1;
    localparam upc_t U_DELAY      = 6'd3;
    localparam upc_t U_DELAY_END  = 6'd5;
    localparam upc_t U_STATUS_RD  = 6'd12;
    localparam upc_t U_STATUS     = 6'd13;
    localparam upc_t U_BSY        = 6'd15;
    localparam upc_t U_POLL_AGAIN = 6'd17;
    localparam upc_t U_DRQ_START  = 6'd18;
    localparam upc_t U_DRQ        = 6'd19;
    localparam upc_t U_FAIL_DRQ   = 6'd22;
    localparam upc_t U_FAIL_NODEV = 6'd23;
    localparam upc_t U_FAIL_BSY   = 6'd24;
    localparam upc_t U_FAIL_ERR   = 6'd25;
    localparam upc_t U_DATA_START = 6'd26;
    localparam upc_t U_DATA       = 6'd27;
    localparam upc_t U_REPORT     = 6'd29;
    localparam upc_t U_CHAR_RD    = 6'd30;

    function automatic uword_t u_report(input outcome_t oc);
        uword_t u;
        u         = '0;
        u.emit    = 1'b1;
        u.kind    = K_REPORT;
        u.outcome = oc;
        u.last    = 1'b1;
        u.ph_we   = 1'b1;
        u.ph      = PH_IDLE;
        u.cond    = C_ALWAYS;
        u.target  = U_WAIT;
        return u;
    endfunction

    // final access of a step: one read, then back to waiting for its response
    function automatic uword_t u_read(input kind_t k, input port_sel_t p, input logic [2:0] o);
        uword_t u;
        u        = '0;
        u.emit   = 1'b1;
        u.kind   = k;
        u.port   = p;
        u.off    = o;
        u.last   = 1'b1;
        u.cond   = C_ALWAYS;
        u.target = U_WAIT;
        return u;
    endfunction

    function automatic uword_t u_write(input logic [2:0] o, input logic [7:0] v);
        uword_t u;
        u      = '0;
        u.emit = 1'b1;
        u.kind = K_WRITE;
        u.port = P_CMD;
        u.off  = o;
        u.wval = v;
        return u;
    endfunction

    function automatic uword_t ucode(input upc_t a);
        uword_t u;
        u = '0;
        unique case (a)
            6'd0:  u.wait_in = 1'b1;
            6'd1:  begin
                u = u_write(REG_DEVICE, 8'h00);
                u.drv_val = 1'b1;
                u.op = OP_START_CLR;
            end
            6'd2:  begin
                u = u_read(K_READ_BYTE, P_CTRL, REG_DATA);
                u.ph_we = 1'b1; u.ph = PH_WAIT_SEL;
            end
            6'd3:  begin
                u.op = OP_DELAY_INC; u.cond = C_DELAY_WRAP; u.target = U_DELAY_END;
            end
            6'd4:  u = u_read(K_READ_BYTE, P_CTRL, REG_DATA);
            6'd5:  begin
                u.cond = C_PHASE_CMD; u.target = U_STATUS_RD;
            end
            6'd6:  u = u_write(REG_COUNT, 8'h00);
            6'd7:  u = u_write(REG_LBA0, 8'h00);
            6'd8:  u = u_write(REG_LBA1, 8'h00);
            6'd9:  u = u_write(REG_LBA2, 8'h00);
            6'd10: u = u_write(REG_CMDST, CMD_IDENTIFY);
            6'd11: begin
                u = u_read(K_READ_BYTE, P_CTRL, REG_DATA);
                u.ph_we = 1'b1; u.ph = PH_WAIT_CMD;
            end
            6'd12: begin
                u = u_read(K_READ_BYTE, P_CMD, REG_CMDST);
                u.ph_we = 1'b1; u.ph = PH_STATUS;
            end
            6'd13: begin
                u.cond = C_STATUS_ZERO; u.target = U_FAIL_NODEV;
            end
            6'd14: begin
                u = u_read(K_READ_BYTE, P_CMD, REG_CMDST);
                u.op = OP_POLL_ONE; u.ph_we = 1'b1; u.ph = PH_BSY;
            end
            6'd15: begin
                u.cond = C_NOT_BSY; u.target = U_DRQ_START;
            end
            6'd16: begin
                u.cond = C_POLL_DONE; u.target = U_FAIL_BSY;
            end
            6'd17: begin
                u = u_read(K_READ_BYTE, P_CMD, REG_CMDST);
                u.op = OP_POLL_INC;
            end
            6'd18: begin
                u = u_read(K_READ_BYTE, P_CMD, REG_CMDST);
                u.op = OP_POLL_ONE; u.ph_we = 1'b1; u.ph = PH_DRQ;
            end
            6'd19: begin
                u.cond = C_ERR; u.target = U_FAIL_ERR;
            end
            6'd20: begin
                u.cond = C_DRQ; u.target = U_DATA_START;
            end
            6'd21: begin
                u.cond = C_POLL_MORE; u.target = U_POLL_AGAIN;
            end
            6'd22: u = u_report(O_DRQ_TIMEOUT);
            6'd23: u = u_report(O_NO_DEVICE);
            6'd24: u = u_report(O_BSY_TIMEOUT);
            6'd25: u = u_report(O_DEV_ERROR);
            6'd26: begin
                u = u_read(K_READ_WORD, P_CMD, REG_DATA);
                u.op = OP_WORD_CLR; u.ph_we = 1'b1; u.ph = PH_DATA;
            end
            6'd27: begin
                u.op = OP_TAKE_WORD; u.cond = C_WORD_LAST; u.target = U_REPORT;
            end
            6'd28: u = u_read(K_READ_WORD, P_CMD, REG_DATA);
            6'd29: u.op = OP_CHAR_CLR;
            6'd30: u.op = OP_NONE;  // text memory read settles
            6'd31: begin
                u.emit = 1'b1; u.kind = K_CHAR; u.op = OP_CHAR_INC;
                u.cond = C_CHAR_MORE; u.target = U_CHAR_RD;
            end
            6'd32: u.op = OP_FOUND_INC;
            6'd33: u = u_report(O_FOUND);
            default: begin
                u.cond = C_ALWAYS; u.target = U_WAIT;
            end
        endcase
        return u;
    endfunction

    // entry point for an accepted beat
    function automatic upc_t dispatch(input logic oper, input phase_t ph);
        upc_t t;
        t = U_WAIT;
        if (oper == OPER_START) begin
            t = U_START;
        end else begin
            unique case (ph)
                PH_WAIT_SEL, PH_WAIT_CMD: t = U_DELAY;
                PH_STATUS:                t = U_STATUS;
                PH_BSY:                   t = U_BSY;
                PH_DRQ:                   t = U_DRQ;
                PH_DATA:                  t = U_DATA;
                default:                  t = U_WAIT;
            endcase
        end
        return t;
    endfunction

endpackage

@@ src/aid_regs.sv @@
// aid_regs: apb configuration registers (command base, control port, poll limit)
// depends on aid_pkg
`timescale 1ns / 1ps

module aid_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aid_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [aid_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [aid_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output aid_pkg::cfg_t                  cfg
);

    aid_pkg::cfg_t       cfg_reg, cfg_next;
    aid_pkg::cfg_index_t index;
    logic                wr_en;

    assign index  = aid_pkg::cfg_index_t'(paddr[aid_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (index)
                aid_pkg::CFG_COMMAND_BASE: cfg_next.command_base = pwdata[15:0];
                aid_pkg::CFG_CONTROL_PORT: cfg_next.control_port = pwdata[15:0];
                aid_pkg::CFG_POLL_LIMIT:
                    cfg_next.poll_limit = pwdata[aid_pkg::LIMIT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            aid_pkg::CFG_COMMAND_BASE: prdata = {16'b0, cfg_reg.command_base};
            aid_pkg::CFG_CONTROL_PORT: prdata = {16'b0, cfg_reg.control_port};
            aid_pkg::CFG_POLL_LIMIT:
                prdata = {{(aid_pkg::CFG_DATA_W - aid_pkg::LIMIT_W){1'b0}},
                          cfg_reg.poll_limit};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_base <= aid_pkg::RST_COMMAND_BASE;
            cfg_reg.control_port <= aid_pkg::RST_CONTROL_PORT;
            cfg_reg.poll_limit   <= aid_pkg::RST_POLL_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/aid_store.sv @@
// aid_store: identify text memory, trailing-space trackers, capacity words and lba48 flag
// depends on aid_pkg
`timescale 1ns / 1ps

module aid_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  aid_pkg::store_ctl_t ctl,
    output logic [7:0]          char_value,
    output logic                lba48,
    output logic [63:0]         capacity
);

    localparam int SER_LAST_W = 5;
    localparam int MOD_LAST_W = 6;

    logic [15:0] text_mem [aid_pkg::TEXT_WORDS];
    logic [15:0] rd_reg;
    logic [15:0] cap_reg [aid_pkg::CAP_WORDS];

    logic [SER_LAST_W-1:0] ser_last_reg, ser_last_next;
    logic [MOD_LAST_W-1:0] mod_last_reg, mod_last_next;
    logic                  lba48_reg, lba48_next;

    logic [aid_pkg::WORD_W-1:0]  word;
    logic [aid_pkg::WORD_W-1:0]  ser_off, mod_off, text_off, cap_slot;
    logic                        in_serial, in_model;
    logic [7:0]                  hi_byte, lo_byte;
    logic [aid_pkg::TEXT_AW-1:0] waddr;
    logic [7:0]                  rd_byte;
    logic                        keep;
    logic [MOD_LAST_W-1:0]       model_pos;

    assign word      = ctl.word_idx;
    assign hi_byte   = ctl.data[15:8];
    assign lo_byte   = ctl.data[7:0];
    assign in_serial = (word >= aid_pkg::W_SERIAL_LO) && (word <= aid_pkg::W_SERIAL_HI);
    assign in_model  = (word >= aid_pkg::W_MODEL_LO) && (word <= aid_pkg::W_MODEL_HI);
    assign ser_off   = word - aid_pkg::W_SERIAL_LO;
    assign mod_off   = word - aid_pkg::W_MODEL_LO;
    // model words follow the ten serial words in the memory
    assign text_off  = in_serial ? ser_off
                                 : mod_off + aid_pkg::WORD_W'(aid_pkg::SERIAL_CHARS / 2);
    assign waddr     = text_off[aid_pkg::TEXT_AW-1:0];
    assign cap_slot  = (word == aid_pkg::W_CAP28_HI) ? aid_pkg::WORD_W'(1)
                     : (word == aid_pkg::W_CAP28_LO) ? aid_pkg::WORD_W'(0)
                     : word - aid_pkg::CAP48_SHIFT;

    always_comb begin
        ser_last_next = ser_last_reg;
        mod_last_next = mod_last_reg;
        lba48_next    = lba48_reg;
        if (ctl.clr) begin
            ser_last_next = '0;
            mod_last_next = '0;
            lba48_next    = 1'b0;
        end else if (ctl.take) begin
            // lower byte sits at the higher position, so it wins
            if (in_serial) begin
                if (lo_byte != aid_pkg::CHAR_SPACE) begin
                    ser_last_next = {ser_off[SER_LAST_W-2:0], 1'b0} + SER_LAST_W'(2);
                end else if (hi_byte != aid_pkg::CHAR_SPACE) begin
                    ser_last_next = {ser_off[SER_LAST_W-2:0], 1'b1};
                end
            end
            if (in_model) begin
                if (lo_byte != aid_pkg::CHAR_SPACE) begin
                    mod_last_next = {mod_off[MOD_LAST_W-2:0], 1'b0} + MOD_LAST_W'(2);
                end else if (hi_byte != aid_pkg::CHAR_SPACE) begin
                    mod_last_next = {mod_off[MOD_LAST_W-2:0], 1'b1};
                end
            end
            if (word == aid_pkg::W_CMDSET) begin
                lba48_next = ctl.data[aid_pkg::LBA48_BIT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_last_reg <= '0;
            mod_last_reg <= '0;
            lba48_reg    <= 1'b0;
        end else begin
            ser_last_reg <= ser_last_next;
            mod_last_reg <= mod_last_next;
            lba48_reg    <= lba48_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take && (in_serial || in_model)) begin
            text_mem[waddr] <= ctl.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= text_mem[ctl.char_idx[aid_pkg::CHAR_W-1:1]];
    end

    always_ff @(posedge aclk) begin
        if (ctl.take && ((word == aid_pkg::W_CAP28_LO) || (word == aid_pkg::W_CAP28_HI) ||
                         ((word >= aid_pkg::W_CAP48_LO) && (word <= aid_pkg::W_CAP48_HI)))) begin
            cap_reg[cap_slot[2:0]] <= ctl.data;
        end
    end

    // even index is the high byte of a word
    assign rd_byte   = ctl.char_idx[0] ? rd_reg[7:0] : rd_reg[15:8];
    assign model_pos = ctl.char_idx - aid_pkg::CHAR_W'(aid_pkg::SERIAL_CHARS);
    assign keep      = (ctl.char_idx < aid_pkg::CHAR_W'(aid_pkg::SERIAL_CHARS))
                     ? (ctl.char_idx[SER_LAST_W-1:0] < ser_last_reg)
                     : (model_pos < mod_last_reg);

    assign char_value = keep ? rd_byte : 8'h00;
    assign lba48      = lba48_reg;
    assign capacity   = lba48_reg ? {cap_reg[5], cap_reg[4], cap_reg[3], cap_reg[2]}
                                  : {32'b0, cap_reg[1], cap_reg[0]};

endmodule

@@ src/aid_ctrl.sv @@
// aid_ctrl: micro-program counter, control rom fetch, dispatch and conditional jumps
// depends on aid_pkg
`timescale 1ns / 1ps

module aid_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_operation,
    input  aid_pkg::flags_t flags,
    input  logic            out_free,
    output logic            s_ready,
    output aid_pkg::uword_t uw,
    output logic            fire
);

    aid_pkg::upc_t upc_reg, upc_next;
    logic          cond_true;

    assign uw      = aid_pkg::ucode(upc_reg);
    assign s_ready = uw.wait_in;
    // a step that drives a beat holds until the output register is free
    assign fire    = uw.wait_in ? s_valid : (!uw.emit || out_free);

    always_comb begin
        unique case (uw.cond)
            aid_pkg::C_NEVER:       cond_true = 1'b0;
            aid_pkg::C_ALWAYS:      cond_true = 1'b1;
            aid_pkg::C_DELAY_WRAP:  cond_true = flags.delay_wrap;
            aid_pkg::C_PHASE_CMD:   cond_true = (flags.phase == aid_pkg::PH_WAIT_CMD);
            aid_pkg::C_STATUS_ZERO: cond_true = flags.status_zero;
            aid_pkg::C_NOT_BSY:     cond_true = flags.not_bsy;
            aid_pkg::C_POLL_DONE:   cond_true = flags.poll_done;
            aid_pkg::C_POLL_MORE:   cond_true = !flags.poll_done;
            aid_pkg::C_ERR:         cond_true = flags.err;
            aid_pkg::C_DRQ:         cond_true = flags.drq;
            aid_pkg::C_WORD_LAST:   cond_true = flags.word_last;
            aid_pkg::C_CHAR_MORE:   cond_true = flags.char_more;
            default:                cond_true = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        if (fire) begin
            if (uw.wait_in) begin
                upc_next = aid_pkg::dispatch(s_operation, flags.phase);
            end else if (cond_true) begin
                upc_next = uw.target;
            end else begin
                upc_next = upc_reg + aid_pkg::UPC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= aid_pkg::U_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ src/aid_dpath.sv @@
// aid_dpath: counters, ata phase, latched response and the result output register
// depends on aid_pkg; driven by the control words of aid_ctrl
`timescale 1ns / 1ps

module aid_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  aid_pkg::cfg_t       cfg,
    input  aid_pkg::uword_t     uw,
    input  logic                fire,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_operation,
    input  logic                s_drive,
    input  logic [15:0]         s_read_data,
    input  logic [7:0]          st_char_value,
    input  logic                st_lba48,
    input  logic [63:0]         st_capacity,
    input  logic                m_ready,
    output aid_pkg::flags_t     flags,
    output aid_pkg::store_ctl_t store_ctl,
    output logic                out_free,
    output logic                m_valid,
    output logic [2:0]          m_kind,
    output logic [15:0]         m_port_address,
    output logic [7:0]          m_write_value,
    output logic [7:0]          m_char_value,
    output logic [5:0]          m_char_index,
    output logic                m_lba48,
    output logic [63:0]         m_capacity,
    output logic [2:0]          m_outcome,
    output logic [2:0]          m_device_count,
    output logic                m_last
);

    aid_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                      delay_reg, delay_next;
    logic [aid_pkg::LIMIT_W-1:0]     poll_reg, poll_next;
    logic [aid_pkg::WORD_W-1:0]      word_reg, word_next;
    logic [aid_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic [2:0]                      found_reg, found_next;
    logic                            drive_reg, drive_next;
    logic [15:0]                     data_reg, data_next;

    logic                            m_valid_reg, m_valid_next;
    logic [2:0]                      kind_reg, kind_next;
    logic [15:0]                     addr_reg, addr_next;
    logic [7:0]                      wval_reg, wval_next;
    logic [7:0]                      cval_reg, cval_next;
    logic [5:0]                      cidx_reg, cidx_next;
    logic                            lba_reg, lba_next;
    logic [63:0]                     cap_reg, cap_next;
    logic [2:0]                      outc_reg, outc_next;
    logic [2:0]                      cnt_reg, cnt_next;
    logic                            last_reg, last_next;

    logic                            accept;
    logic [aid_pkg::LIMIT_W-1:0]     limit_eff;
    logic [7:0]                      status;
    logic                            found_rep;
    logic                            load;

    assign accept    = s_valid && s_ready;
    assign status    = data_reg[7:0];
    assign limit_eff = (cfg.poll_limit == '0) ? aid_pkg::LIMIT_W'(1) : cfg.poll_limit;
    assign out_free  = !m_valid_reg || m_ready;
    assign load      = fire && uw.emit;

    assign flags.phase       = phase_reg;
    assign flags.delay_wrap  = (delay_reg == 2'd3);
    assign flags.status_zero = (status == 8'h00);
    assign flags.not_bsy     = ((status & aid_pkg::ST_BSY) == 8'h00);
    assign flags.poll_done   = (poll_reg >= limit_eff);
    assign flags.err         = ((status & aid_pkg::ST_ERR) != 8'h00);
    assign flags.drq         = ((status & aid_pkg::ST_DRQ) != 8'h00);
    assign flags.word_last   =
        (word_reg == aid_pkg::WORD_W'(aid_pkg::IDENTIFY_WORDS - 1));
    assign flags.char_more   = (char_reg != aid_pkg::CHAR_W'(aid_pkg::CHAR_COUNT - 1));

    assign store_ctl.clr      = fire && (uw.op == aid_pkg::OP_START_CLR);
    assign store_ctl.take     = fire && (uw.op == aid_pkg::OP_TAKE_WORD);
    assign store_ctl.word_idx = word_reg;
    assign store_ctl.data     = data_reg;
    assign store_ctl.char_idx = char_reg;

    // counters and phase
    always_comb begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        word_next  = word_reg;
        char_next  = char_reg;
        found_next = found_reg;
        drive_next = drive_reg;
        data_next  = data_reg;
        if (accept) begin
            data_next = s_read_data;
            if (s_operation == aid_pkg::OPER_START) begin
                drive_next = s_drive;
            end
        end
        if (fire) begin
            if (uw.ph_we) begin
                phase_next = uw.ph;
            end
            unique case (uw.op)
                aid_pkg::OP_NONE: ;
                aid_pkg::OP_START_CLR: begin
                    delay_next = '0;
                    poll_next  = '0;
                    word_next  = '0;
                end
                aid_pkg::OP_DELAY_INC: delay_next = delay_reg + 2'd1;
                aid_pkg::OP_POLL_ONE:  poll_next  = aid_pkg::LIMIT_W'(1);
                aid_pkg::OP_POLL_INC:  poll_next  = poll_reg + aid_pkg::LIMIT_W'(1);
                aid_pkg::OP_WORD_CLR:  word_next  = '0;
                aid_pkg::OP_TAKE_WORD: word_next  = word_reg + aid_pkg::WORD_W'(1);
                aid_pkg::OP_CHAR_CLR:  char_next  = '0;
                aid_pkg::OP_CHAR_INC:  char_next  = char_reg + aid_pkg::CHAR_W'(1);
                aid_pkg::OP_FOUND_INC: begin
                    if (found_reg < aid_pkg::MAX_DEVICES) begin
                        found_next = found_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result beat fields
    assign found_rep = (uw.kind == aid_pkg::K_REPORT) && (uw.outcome == aid_pkg::O_FOUND);

    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        wval_next    = wval_reg;
        cval_next    = cval_reg;
        cidx_next    = cidx_reg;
        lba_next     = lba_reg;
        cap_next     = cap_reg;
        outc_next    = outc_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        if (load) begin
            m_valid_next = 1'b1;
            kind_next    = uw.kind;
            unique case (uw.port)
                aid_pkg::P_CMD:  addr_next = cfg.command_base + {13'b0, uw.off};
                aid_pkg::P_CTRL: addr_next = cfg.control_port;
                default:         addr_next = '0;
            endcase
            if (uw.kind != aid_pkg::K_WRITE) begin
                wval_next = 8'h00;
            end else if (uw.drv_val) begin
                wval_next = drive_reg ? aid_pkg::SEL_SLAVE : aid_pkg::SEL_MASTER;
            end else begin
                wval_next = uw.wval;
            end
            cval_next = (uw.kind == aid_pkg::K_CHAR) ? st_char_value : 8'h00;
            cidx_next = (uw.kind == aid_pkg::K_CHAR) ? char_reg : 6'd0;
            lba_next  = found_rep ? st_lba48 : 1'b0;
            cap_next  = found_rep ? st_capacity : 64'd0;
            outc_next = (uw.kind == aid_pkg::K_REPORT) ? uw.outcome : 3'd0;
            cnt_next  = (uw.kind == aid_pkg::K_REPORT) ? found_reg : 3'd0;
            last_next = uw.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= aid_pkg::PH_IDLE;
            delay_reg   <= '0;
            poll_reg    <= '0;
            word_reg    <= '0;
            char_reg    <= '0;
            found_reg   <= '0;
            drive_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            delay_reg   <= delay_next;
            poll_reg    <= poll_next;
            word_reg    <= word_next;
            char_reg    <= char_next;
            found_reg   <= found_next;
            drive_reg   <= drive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        wval_reg <= wval_next;
        cval_reg <= cval_next;
        cidx_reg <= cidx_next;
        lba_reg  <= lba_next;
        cap_reg  <= cap_next;
        outc_reg <= outc_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_port_address = addr_reg;
    assign m_write_value  = wval_reg;
    assign m_char_value   = cval_reg;
    assign m_char_index   = cidx_reg;
    assign m_lba48        = lba_reg;
    assign m_capacity     = cap_reg;
    assign m_outcome      = outc_reg;
    assign m_device_count = cnt_reg;
    assign m_last         = last_reg;

endmodule

@@ src/ata_identify_sequencer_top.sv @@
// ata_identify_sequencer_top: ata pio identify sequencer, top level
// depends on aid_pkg, aid_regs, aid_store, aid_ctrl, aid_dpath
`timescale 1ns / 1ps

// Input beats (s_*): a start beat (operation 0, drive) or the response to the
// last requested read (operation 1, read_data). Result beats (m_*) are port
// accesses (write byte, read byte, read word), identity characters and a final
// report; m_last marks the last beat caused by an input beat.
// A microcoded sequencer walks a 34-step control rom, one step per cycle; a
// step that drives a result beat waits for the output register.
// Beats: a start beat gives its 2 beats; a delay or poll response gives its
// beat once accepted; the delay that follows the select write gives 6 beats.
// The response to the last data word gives 60 characters (one text memory
// read per character) and then the report. One input beat is worked on at a
// time; s_ready is high only while the sequencer waits for input.
// Reset (synchronous, aresetn low) puts the registers at 0x1F0 / 0x3F6 /
// 100000, the phase idle and the device count zero; no clearing pass is needed.
// When the receiver stalls, the current result beat holds in the output
// register and the sequencer stalls on its next beat-driving step.
// Configuration (apb, registers at 0x0, 0x4, 0x8) must be written by the user
// only while idle; the block itself does not enforce it.

module ata_identify_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic        s_drive,
    input  logic [15:0] s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_port_address,
    output logic [7:0]  m_write_value,
    output logic [7:0]  m_char_value,
    output logic [5:0]  m_char_index,
    output logic        m_lba48,
    output logic [63:0] m_capacity,
    output logic [2:0]  m_outcome,
    output logic [2:0]  m_device_count,
    output logic        m_last
);

    aid_pkg::cfg_t       cfg;
    aid_pkg::uword_t     uw;
    aid_pkg::flags_t     flags;
    aid_pkg::store_ctl_t store_ctl;
    logic                fire;
    logic                out_free;
    logic [7:0]          st_char_value;
    logic                st_lba48;
    logic [63:0]         st_capacity;

    aid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aid_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .flags       (flags),
        .out_free    (out_free),
        .s_ready     (s_ready),
        .uw          (uw),
        .fire        (fire)
    );

    aid_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (store_ctl),
        .char_value (st_char_value),
        .lba48      (st_lba48),
        .capacity   (st_capacity)
    );

    aid_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .uw             (uw),
        .fire           (fire),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_drive        (s_drive),
        .s_read_data    (s_read_data),
        .st_char_value  (st_char_value),
        .st_lba48       (st_lba48),
        .st_capacity    (st_capacity),
        .m_ready        (m_ready),
        .flags          (flags),
        .store_ctl      (store_ctl),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_kind         (m_kind),
        .m_port_address (m_port_address),
        .m_write_value  (m_write_value),
        .m_char_value   (m_char_value),
        .m_char_index   (m_char_index),
        .m_lba48        (m_lba48),
        .m_capacity     (m_capacity),
        .m_outcome      (m_outcome),
        .m_device_count (m_device_count),
        .m_last         (m_last)
    );

endmodule
